// ===== rtl/core/stc_pkg.sv =====
package stc_pkg;

    localparam int POS_BITS = 32;

    localparam logic KIND_CLASS = 1'b0;
    localparam logic KIND_BIN   = 1'b1;

    typedef struct packed {
        logic        last;
        logic        kind;
        logic [31:0] bin_count;
        logic [5:0]  bin_index;
        logic [31:0] longer_than_max;
        logic [32:0] total_sstar_length;
        logic [31:0] count_sstar;
        logic [32:0] count_stype;
        logic [31:0] sstar_length;
        logic        sstar_found;
        logic        is_stype;
        logic [31:0] position;
    } result_t;

endpackage

// ===== rtl/core/stc_ram.sv =====
module stc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 51
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/stc_skid.sv =====
module stc_skid (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  stc_pkg::result_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output stc_pkg::result_t out_data
);

    import stc_pkg::*;

    result_t main_reg;
    result_t skid_reg;
    logic    main_valid_reg;
    logic    skid_valid_reg;
    logic    in_fire;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_reg       <= '0;
            skid_reg       <= '0;
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                main_reg       <= skid_reg;
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else if (in_fire)
            begin
                main_reg       <= in_data;
                main_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b0;
            end
        end
        else if (in_fire)
        begin
            skid_reg       <= in_data;
            skid_valid_reg <= 1'b1;
        end
    end

endmodule

// ===== rtl/core/suffix_type_classifier_top.sv =====
// suffix type classifier: S/L typing of a text fed from its last position down to 0
//
// input stream: one symbol per transaction, tdata = symbol, tuser = special flag.
// output stream: one classification transaction per symbol (tuser = 0), and after
// position 0 one histogram transaction per bin 0..HIST_MAX_LEN (tuser = 1), the
// last of them with tlast set.
// configuration: cfg_wr_en/cfg_wr_data write total_length and restart the run;
// write only while the block is idle.
// throughput: one symbol per cycle while running and not stalled; a classification
// result is loaded into the output stage at the edge that takes its symbol.
// end of run: input is held off through the drain state and while the histogram
// memory is read out through its single read port, one bin per cycle unless the
// output stage is full; statistics are then cleared and the next run starts.
// output stall: a two-entry output stage holds results; it holds off the input
// only when both entries are full.
// reset: total_length = 1, empty statistics, the histogram reads as all zero.
module suffix_type_classifier_top #(
    parameter int HIST_MAX_LEN = 50
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // symbol
    input  logic         s_tuser,   // is_special
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [239:0] m_tdata,   // position, is_stype, sstar_found, sstar_length,
                                    // count_stype, count_sstar, total_sstar_length,
                                    // longer_than_max, bin_index, bin_count, zero pad
    output logic         m_tuser,   // kind
    output logic         m_tlast    // last
);

    import stc_pkg::*;

    localparam int BINS     = HIST_MAX_LEN + 1;
    localparam int BIN_BITS = $clog2(BINS);

    typedef enum logic [1:0] {ST_RUN, ST_DRAIN, ST_READOUT} state_t;

    state_t               state_reg;
    logic [31:0]          total_length_reg;
    logic [POS_BITS-1:0]  pos_reg;
    logic [31:0]          next_symbol_reg;
    logic                 next_special_reg;
    logic                 next_is_s_reg;
    logic [POS_BITS-1:0]  next_sstar_pos_reg;
    logic [32:0]          stype_total_reg;
    logic [31:0]          sstar_total_reg;
    logic [32:0]          sstar_sum_reg;
    logic [31:0]          overflow_reg;
    logic [BINS-1:0]      hist_valid_reg;

    logic                 upd_pend_reg;
    logic [BIN_BITS-1:0]  upd_addr_reg;
    logic                 upd_hit_reg;

    logic [BIN_BITS-1:0]  rd_addr_reg;
    logic                 rd_all_reg;
    logic                 rd_pend_reg;
    logic [BIN_BITS-1:0]  rd_bin_reg;
    logic                 rd_hit_reg;

    logic [32:0]          stype_total_next;
    logic [31:0]          sstar_total_next;
    logic [32:0]          sstar_sum_next;
    logic [31:0]          overflow_next;

    logic                 skid_in_valid;
    logic                 skid_in_ready;
    result_t              skid_in_data;
    result_t              out_data;

    logic                 in_fire;
    logic                 cur_s;
    logic                 found;
    logic [POS_BITS-1:0]  sstar_len;
    logic                 in_hist;
    logic [BIN_BITS-1:0]  len_bin;
    logic                 upd_start;

    logic                 rd_push;
    logic                 rd_issue;
    logic                 rd_last;

    logic                 ram_we;
    logic [31:0]          ram_wdata;
    logic                 ram_re;
    logic [BIN_BITS-1:0]  ram_raddr;
    logic [31:0]          ram_rdata;

    logic [31:0]          start_len_raw;
    logic [POS_BITS-1:0]  start_len;
    logic                 restart;

    result_t              class_res;
    result_t              bin_res;

    // classification
    assign in_fire = s_tvalid && s_tready;

    always_comb
    begin
        if (s_tuser)
        begin
            cur_s = 1'b0;
        end
        else if (next_special_reg)
        begin
            cur_s = 1'b1;
        end
        else
        begin
            cur_s = (s_tdata < next_symbol_reg) ||
                    ((s_tdata == next_symbol_reg) && next_is_s_reg);
        end
    end

    assign found     = !cur_s && next_is_s_reg;
    assign sstar_len = next_sstar_pos_reg - pos_reg;
    assign in_hist   = sstar_len <= POS_BITS'(HIST_MAX_LEN);
    assign len_bin   = sstar_len[BIN_BITS-1:0];
    assign upd_start = in_fire && found && in_hist;

    assign stype_total_next = stype_total_reg + 33'(cur_s);
    assign sstar_total_next = sstar_total_reg + 32'(found);
    assign sstar_sum_next   = found ? sstar_sum_reg + 33'(sstar_len) : sstar_sum_reg;
    assign overflow_next    = overflow_reg + 32'(found && !in_hist);

    always_comb
    begin
        class_res                    = '0;
        class_res.kind               = KIND_CLASS;
        class_res.position           = pos_reg;
        class_res.is_stype           = cur_s;
        class_res.sstar_found        = found;
        class_res.sstar_length       = found ? sstar_len : '0;
        class_res.count_stype        = stype_total_next;
        class_res.count_sstar        = sstar_total_next;
        class_res.total_sstar_length = sstar_sum_next;
        class_res.longer_than_max    = overflow_next;
    end

    // histogram readout
    assign rd_push  = (state_reg == ST_READOUT) && rd_pend_reg && skid_in_ready;
    assign rd_issue = (state_reg == ST_READOUT) && !rd_all_reg && (!rd_pend_reg || rd_push);
    assign rd_last  = rd_bin_reg == BIN_BITS'(HIST_MAX_LEN);

    always_comb
    begin
        bin_res                    = '0;
        bin_res.kind               = KIND_BIN;
        bin_res.count_stype        = stype_total_reg;
        bin_res.count_sstar        = sstar_total_reg;
        bin_res.total_sstar_length = sstar_sum_reg;
        bin_res.longer_than_max    = overflow_reg;
        bin_res.bin_index          = 6'(rd_bin_reg);
        bin_res.bin_count          = rd_hit_reg ? ram_rdata : '0;
        bin_res.last               = rd_last;
    end

    // histogram memory port control
    assign ram_re    = (state_reg == ST_READOUT) ? rd_issue : upd_start;
    assign ram_raddr = (state_reg == ST_READOUT) ? rd_addr_reg : len_bin;
    assign ram_we    = upd_pend_reg;
    assign ram_wdata = (upd_hit_reg ? ram_rdata : '0) + 32'd1;

    assign skid_in_valid = in_fire || rd_push;
    assign skid_in_data  = (state_reg == ST_READOUT) ? bin_res : class_res;
    assign s_tready      = (state_reg == ST_RUN) && skid_in_ready;

    // run start values
    assign restart       = cfg_wr_en || (rd_push && rd_last);
    assign start_len_raw = cfg_wr_en ? cfg_wr_data : total_length_reg;
    assign start_len     = (start_len_raw[POS_BITS-1:0] == '0) ?
                           POS_BITS'(1) : start_len_raw[POS_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_RUN;
            total_length_reg   <= 32'd1;
            pos_reg            <= '0;
            next_symbol_reg    <= '0;
            next_special_reg   <= 1'b1;
            next_is_s_reg      <= 1'b1;
            next_sstar_pos_reg <= POS_BITS'(1);
            stype_total_reg    <= 33'd1;
            sstar_total_reg    <= '0;
            sstar_sum_reg      <= '0;
            overflow_reg       <= '0;
            hist_valid_reg     <= '0;
            upd_pend_reg       <= 1'b0;
            upd_addr_reg       <= '0;
            upd_hit_reg        <= 1'b0;
            rd_addr_reg        <= '0;
            rd_all_reg         <= 1'b0;
            rd_pend_reg        <= 1'b0;
            rd_bin_reg         <= '0;
            rd_hit_reg         <= 1'b0;
        end
        else
        begin
            if (upd_pend_reg)
            begin
                hist_valid_reg[upd_addr_reg] <= 1'b1;
            end
            upd_pend_reg <= upd_start;
            if (upd_start)
            begin
                upd_addr_reg <= len_bin;
                upd_hit_reg  <= hist_valid_reg[len_bin];
            end

            case (state_reg)
                ST_RUN:
                begin
                    if (in_fire)
                    begin
                        next_symbol_reg  <= s_tdata;
                        next_special_reg <= s_tuser;
                        next_is_s_reg    <= cur_s;
                        stype_total_reg  <= stype_total_next;
                        sstar_total_reg  <= sstar_total_next;
                        sstar_sum_reg    <= sstar_sum_next;
                        overflow_reg     <= overflow_next;
                        if (found)
                        begin
                            next_sstar_pos_reg <= pos_reg + POS_BITS'(1);
                        end
                        if (pos_reg == '0)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                        else
                        begin
                            pos_reg <= pos_reg - POS_BITS'(1);
                        end
                    end
                end
                ST_DRAIN:
                begin
                    rd_addr_reg <= '0;
                    rd_all_reg  <= 1'b0;
                    rd_pend_reg <= 1'b0;
                    state_reg   <= ST_READOUT;
                end
                ST_READOUT:
                begin
                    if (rd_issue)
                    begin
                        rd_pend_reg <= 1'b1;
                        rd_bin_reg  <= rd_addr_reg;
                        rd_hit_reg  <= hist_valid_reg[rd_addr_reg];
                        if (rd_addr_reg == BIN_BITS'(HIST_MAX_LEN))
                        begin
                            rd_all_reg <= 1'b1;
                        end
                        else
                        begin
                            rd_addr_reg <= rd_addr_reg + BIN_BITS'(1);
                        end
                    end
                    else if (rd_push)
                    begin
                        rd_pend_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_RUN;
                end
            endcase

            if (cfg_wr_en)
            begin
                total_length_reg <= cfg_wr_data;
            end
            if (restart)
            begin
                state_reg          <= ST_RUN;
                pos_reg            <= start_len - POS_BITS'(1);
                next_symbol_reg    <= '0;
                next_special_reg   <= 1'b1;
                next_is_s_reg      <= 1'b1;
                next_sstar_pos_reg <= start_len;
                stype_total_reg    <= 33'd1;
                sstar_total_reg    <= '0;
                sstar_sum_reg      <= '0;
                overflow_reg       <= '0;
                hist_valid_reg     <= '0;
                upd_pend_reg       <= 1'b0;
                rd_pend_reg        <= 1'b0;
            end
        end
    end

    stc_ram #(
        .WIDTH (32),
        .DEPTH (BINS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (upd_addr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    stc_skid u_out_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (skid_in_valid),
        .in_ready  (skid_in_ready),
        .in_data   (skid_in_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {6'b0,
                      out_data.bin_count,
                      out_data.bin_index,
                      out_data.longer_than_max,
                      out_data.total_sstar_length,
                      out_data.count_sstar,
                      out_data.count_stype,
                      out_data.sstar_length,
                      out_data.sstar_found,
                      out_data.is_stype,
                      out_data.position};
    assign m_tuser = out_data.kind;
    assign m_tlast = out_data.last;

endmodule
